### hw/rtl/ptc_pkg.sv
// Shared types and constants of the pressure and temperature compensation block.
package ptc_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_C = 2'd3;

  // Depth of the queue between the front and back pipelines.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Compensation constants.
  localparam int      FINE_OFFSET = 128000;
  localparam int      RAW_FULL    = 1048576;
  localparam int      DIV_SCALE   = 3125;
  localparam int      TEMP_LO     = -4000;
  localparam int      TEMP_HI     = 8500;
  localparam longint  PRESS_LO    = 64'sd7680000;
  localparam longint  PRESS_HI    = 64'sd28160000;
  localparam logic [63:0] DIV_BIAS = 64'h0000_8000_0000_0000;

  // Reciprocal constants for the decimal splits.
  localparam logic [12:0] RECIP_100  = 13'd5243;   // 2^19 / 100, rounded up
  localparam int unsigned RECIP_100_SH = 19;
  localparam logic [12:0] RECIP_1000 = 13'd4194;   // 2^22 / 1000, rounded down
  localparam int unsigned RECIP_1000_SH = 22;

  // Calibration words unpacked from the four registers.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  // Finished temperature fields, carried alongside the pressure work.
  typedef struct packed {
    logic [14:0] centi;
    logic [7:0]  whole;
    logic [20:0] micro;
    logic [31:0] fine;
  } temp_t;

  // One queue entry: temperature result plus pressure dividend and divisor.
  typedef struct packed {
    temp_t       temp;
    logic [63:0] num;
    logic [30:0] dvs;
  } qentry_t;

endpackage

### hw/rtl/ptc_if.sv
// Handshake interfaces for raw readings and compensated results.
interface ptc_raw_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_res_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temp_centi;
  logic signed [7:0]  temp_whole;
  logic signed [20:0] temp_micro;
  logic signed [31:0] fine_temp;
  logic [24:0]        press_q24_8;
  logic [6:0]         press_kpa_whole;
  logic [19:0]        press_micro;
  logic               press_valid;

  modport source (output valid, output temp_centi, output temp_whole, output temp_micro,
                  output fine_temp, output press_q24_8, output press_kpa_whole,
                  output press_micro, output press_valid, input ready);
  modport sink (input valid, input temp_centi, input temp_whole, input temp_micro,
                input fine_temp, input press_q24_8, input press_kpa_whole,
                input press_micro, input press_valid, output ready);
endinterface

### hw/rtl/ptc_front.sv
// Front pipeline: temperature compensation and pressure divisor and dividend.
module ptc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptc_pkg::cal_t       cal_i,
  ptc_raw_if.sink             raw_i,
  input  logic                full_i,
  output logic                push_o,
  output ptc_pkg::qentry_t    entry_o
);

  logic [9:1] v_q;
  logic       adv;
  logic       accept;

  // The whole front stalls only when its last stage cannot enter the queue.
  assign adv         = ~(v_q[9] & full_i);
  assign raw_i.ready = adv;
  assign accept      = raw_i.valid & adv;
  assign push_o      = v_q[9] & ~full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[8:1], accept};
    end
  end

  // Stage 1: first temperature products.
  logic signed [18:0] a_s;
  logic signed [17:0] b_s;
  logic signed [34:0] s1_at_q;
  logic signed [35:0] s1_bb_q;
  logic [19:0]        s1_rp_q;

  assign a_s = $signed({2'b00, raw_i.raw_temperature[19:3]}) - $signed({2'b00, cal_i.t1, 1'b0});
  assign b_s = $signed({2'b00, raw_i.raw_temperature[19:4]}) - $signed({2'b00, cal_i.t1});

  // Stage 2: scale and apply t3.
  logic signed [23:0] x1t;
  logic signed [23:0] bbs;
  logic signed [23:0] s2_x1_q;
  logic signed [39:0] s2_x2p_q;
  logic [19:0]        s2_rp_q;

  assign x1t = s1_at_q[34:11];
  assign bbs = s1_bb_q[35:12];

  // Stage 3: fine temperature.
  logic signed [25:0] x2t;
  logic [31:0]        fine;
  logic [31:0]        s3_fine_q;
  logic [19:0]        s3_rp_q;

  assign x2t  = s2_x2p_q[39:14];
  assign fine = {{8{s2_x1_q[23]}}, s2_x1_q} + {{6{x2t[25]}}, x2t};

  // Stage 4: centidegrees with clamp, offset fine term for pressure.
  logic [33:0] f34;
  logic [33:0] t5;
  logic [25:0] tcr;
  logic [14:0] tc;
  logic [14:0] s4_tc_q;
  logic [27:0] s4_dx_q;
  logic [31:0] s4_fine_q;
  logic [19:0] s4_rp_q;

  assign f34 = {{2{s3_fine_q[31]}}, s3_fine_q};
  assign t5  = (f34 << 2) + f34 + 34'd128;
  assign tcr = t5[33:8];

  always_comb begin
    if ($signed(tcr) > ptc_pkg::TEMP_HI) begin
      tc = 15'(ptc_pkg::TEMP_HI);
    end else if ($signed(tcr) < ptc_pkg::TEMP_LO) begin
      tc = 15'(ptc_pkg::TEMP_LO);
    end else begin
      tc = tcr[14:0];
    end
  end

  // Stage 5: magnitude for the decimal split, first pressure products.
  logic [14:0]        tn;
  logic               s5_tneg_q;
  logic [13:0]        s5_n_q;
  logic [26:0]        s5_qm_q;
  logic [14:0]        s5_tc_q;
  logic [31:0]        s5_fine_q;
  logic signed [55:0] s5_sq_q;
  logic signed [43:0] s5_m5_q;
  logic signed [43:0] s5_m2_q;
  logic [19:0]        s5_rp_q;

  assign tn = s4_tc_q[14] ? (15'd0 - s4_tc_q) : s4_tc_q;

  // Stage 6: quotient and remainder by 100, products with p6 and p3.
  logic [7:0]         q100;
  logic [13:0]        q100x;
  logic [13:0]        r100;
  logic signed [71:0] a6_full;
  logic signed [71:0] a3_full;
  logic [6:0]         s6_q_q;
  logic [6:0]         s6_r_q;
  logic               s6_tneg_q;
  logic [14:0]        s6_tc_q;
  logic [31:0]        s6_fine_q;
  logic [63:0]        s6_a6_q;
  logic [63:0]        s6_a3_q;
  logic [43:0]        s6_m5_q;
  logic [43:0]        s6_m2_q;
  logic [19:0]        s6_rp_q;

  assign q100    = s5_qm_q[26:19];
  assign q100x   = 14'(q100) * 14'd100;
  assign r100    = s5_n_q - q100x;
  assign a6_full = s5_sq_q * $signed(cal_i.p6);
  assign a3_full = s5_sq_q * $signed(cal_i.p3);

  // Stage 7: signed decimal split, pressure sums.
  logic [20:0] micro_mag;
  logic [63:0] x2_sum;
  logic [63:0] v_sum;
  ptc_pkg::temp_t s7_temp_q;
  logic [63:0] s7_x2_q;
  logic [63:0] s7_v_q;
  logic [19:0] s7_rp_q;

  assign micro_mag = 21'(s6_r_q) * 21'd10000;
  assign x2_sum = s6_a6_q + {{3{s6_m5_q[43]}}, s6_m5_q, 17'd0}
                + {{13{cal_i.p4[15]}}, cal_i.p4, 35'd0};
  assign v_sum  = {{8{s6_a3_q[63]}}, s6_a3_q[63:8]} + {{8{s6_m2_q[43]}}, s6_m2_q, 12'd0}
                + ptc_pkg::DIV_BIAS;

  // Stage 8: divisor and unscaled dividend.
  logic signed [80:0] dprod;
  logic [20:0]        pr0;
  ptc_pkg::temp_t     s8_temp_q;
  logic [30:0]        s8_dvs_q;
  logic [63:0]        s8_n0_q;

  assign dprod = $signed(s7_v_q) * $signed({1'b0, cal_i.p1});
  assign pr0   = 21'(ptc_pkg::RAW_FULL) - {1'b0, s7_rp_q};

  // Stage 9: scaled dividend.
  ptc_pkg::temp_t s9_temp_q;
  logic [30:0]    s9_dvs_q;
  logic [63:0]    s9_num_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_at_q   <= a_s * $signed(cal_i.t2);
      s1_bb_q   <= b_s * b_s;
      s1_rp_q   <= raw_i.raw_pressure;

      s2_x1_q   <= x1t;
      s2_x2p_q  <= bbs * $signed(cal_i.t3);
      s2_rp_q   <= s1_rp_q;

      s3_fine_q <= fine;
      s3_rp_q   <= s2_rp_q;

      s4_tc_q   <= tc;
      s4_dx_q   <= s3_fine_q[27:0] - 28'(ptc_pkg::FINE_OFFSET);
      s4_fine_q <= s3_fine_q;
      s4_rp_q   <= s3_rp_q;

      s5_tneg_q <= s4_tc_q[14];
      s5_n_q    <= tn[13:0];
      s5_qm_q   <= 27'(tn[13:0]) * 27'(ptc_pkg::RECIP_100);
      s5_tc_q   <= s4_tc_q;
      s5_fine_q <= s4_fine_q;
      s5_sq_q   <= $signed(s4_dx_q) * $signed(s4_dx_q);
      s5_m5_q   <= $signed(s4_dx_q) * $signed(cal_i.p5);
      s5_m2_q   <= $signed(s4_dx_q) * $signed(cal_i.p2);
      s5_rp_q   <= s4_rp_q;

      s6_q_q    <= q100[6:0];
      s6_r_q    <= r100[6:0];
      s6_tneg_q <= s5_tneg_q;
      s6_tc_q   <= s5_tc_q;
      s6_fine_q <= s5_fine_q;
      s6_a6_q   <= a6_full[63:0];
      s6_a3_q   <= a3_full[63:0];
      s6_m5_q   <= s5_m5_q;
      s6_m2_q   <= s5_m2_q;
      s6_rp_q   <= s5_rp_q;

      s7_temp_q.centi <= s6_tc_q;
      s7_temp_q.whole <= s6_tneg_q ? (8'd0 - {1'b0, s6_q_q}) : {1'b0, s6_q_q};
      s7_temp_q.micro <= s6_tneg_q ? (21'd0 - micro_mag) : micro_mag;
      s7_temp_q.fine  <= s6_fine_q;
      s7_x2_q   <= x2_sum;
      s7_v_q    <= v_sum;
      s7_rp_q   <= s6_rp_q;

      s8_temp_q <= s7_temp_q;
      s8_dvs_q  <= dprod[63:33];
      s8_n0_q   <= {12'd0, pr0, 31'd0} - s7_x2_q;

      s9_temp_q <= s8_temp_q;
      s9_dvs_q  <= s8_dvs_q;
      s9_num_q  <= s8_n0_q * 64'(ptc_pkg::DIV_SCALE);
    end
  end

  assign entry_o.temp = s9_temp_q;
  assign entry_o.num  = s9_num_q;
  assign entry_o.dvs  = s9_dvs_q;

endmodule

### hw/rtl/ptc_queue.sv
// Small queue that decouples the front and back pipelines.
module ptc_queue #(
  parameter int unsigned Depth = ptc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ptc_pkg::qentry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ptc_pkg::qentry_t data_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ptc_pkg::qentry_t mem_q [Depth];
  logic [IdxW-1:0]  wr_q;
  logic [IdxW-1:0]  rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  // Pointers and fill count; the sides never push when full or pop when empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/ptc_back.sv
// Back pipeline: pipelined signed divider and final pressure compensation.
module ptc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptc_pkg::cal_t    cal_i,
  input  logic             empty_i,
  input  ptc_pkg::qentry_t entry_i,
  output logic             pop_o,
  ptc_res_if.source        res_o
);

  localparam int unsigned DivSteps = 64;

  logic adv;
  logic ov_q;

  // The back side stalls as a whole while a result waits at the output.
  assign adv   = ~ov_q | res_o.ready;
  assign pop_o = adv & ~empty_i;

  // Divider stage registers; index zero is the sign and magnitude stage.
  logic [DivSteps:0] dv_q;
  logic [30:0]       rem_q   [0:DivSteps];
  logic [63:0]       dq_q    [0:DivSteps];
  logic [30:0]       dm_q    [0:DivSteps];
  logic              qneg_q  [0:DivSteps];
  logic              zero_q  [0:DivSteps];
  ptc_pkg::temp_t    temp_q  [0:DivSteps];

  logic [7:1] bv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      bv_q <= '0;
      ov_q <= 1'b0;
    end else if (adv) begin
      dv_q <= {dv_q[DivSteps-1:0], pop_o};
      bv_q <= {bv_q[6:1], dv_q[DivSteps]};
      ov_q <= bv_q[7];
    end
  end

  // Sign and magnitude of dividend and divisor.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= '0;
      dq_q[0]   <= entry_i.num[63] ? (64'd0 - entry_i.num) : entry_i.num;
      dm_q[0]   <= entry_i.dvs[30] ? (31'd0 - entry_i.dvs) : entry_i.dvs;
      qneg_q[0] <= entry_i.num[63] ^ entry_i.dvs[30];
      zero_q[0] <= entry_i.dvs == '0;
      temp_q[0] <= entry_i.temp;
    end
  end

  // One restoring quotient bit per stage.
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [31:0] rs;
    logic [31:0] rdiff;
    logic        ge;

    assign rs    = {rem_q[i], dq_q[i][63]};
    assign rdiff = rs - {1'b0, dm_q[i]};
    assign ge    = rs >= {1'b0, dm_q[i]};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[i+1]  <= ge ? rdiff[30:0] : rs[30:0];
        dq_q[i+1]   <= {dq_q[i][62:0], ge};
        dm_q[i+1]   <= dm_q[i];
        qneg_q[i+1] <= qneg_q[i];
        zero_q[i+1] <= zero_q[i];
        temp_q[i+1] <= temp_q[i];
      end
    end
  end

  // Stage B1: signed quotient.
  logic [63:0]    b1_q_q;
  logic           b1_zero_q;
  ptc_pkg::temp_t b1_temp_q;

  // Stage B2: products with p9 and p8.
  logic signed [50:0] sq13;
  logic signed [66:0] c9_full;
  logic signed [79:0] m8_full;
  logic [63:0]        b2_q_q;
  logic [50:0]        b2_s_q;
  logic [63:0]        b2_c9s_q;
  logic [63:0]        b2_m8_q;
  logic               b2_zero_q;
  ptc_pkg::temp_t     b2_temp_q;

  assign sq13    = b1_q_q[63:13];
  assign c9_full = $signed(cal_i.p9) * sq13;
  assign m8_full = $signed(cal_i.p8) * $signed(b1_q_q);

  // Stage B3: partial products of the wrapped 64-bit square term.
  logic [63:0]    bs;
  logic [63:0]    pp0;
  logic [31:0]    pp1;
  logic [31:0]    pp2;
  logic [63:0]    b3_pp0_q;
  logic [31:0]    b3_pp1_q;
  logic [31:0]    b3_pp2_q;
  logic [63:0]    b3_x2_q;
  logic [63:0]    b3_q_q;
  logic           b3_zero_q;
  ptc_pkg::temp_t b3_temp_q;

  assign bs  = {{13{b2_s_q[50]}}, b2_s_q};
  assign pp0 = 64'(b2_c9s_q[31:0]) * 64'(bs[31:0]);
  assign pp1 = b2_c9s_q[31:0] * bs[63:32];
  assign pp2 = b2_c9s_q[63:32] * bs[31:0];

  // Stage B4: combine partial products and sum the correction terms.
  logic [63:0]    prod;
  logic [63:0]    x1v;
  logic [63:0]    b4_sum_q;
  logic           b4_zero_q;
  ptc_pkg::temp_t b4_temp_q;

  assign prod = b3_pp0_q + {b3_pp1_q + b3_pp2_q, 32'd0};
  assign x1v  = {{25{prod[63]}}, prod[63:25]};

  // Stage B5: offset by p7 and clamp.
  logic [63:0]    pr;
  logic [24:0]    pq;
  logic [24:0]    b5_pq_q;
  logic           b5_zero_q;
  ptc_pkg::temp_t b5_temp_q;

  assign pr = {{8{b4_sum_q[63]}}, b4_sum_q[63:8]} + {{44{cal_i.p7[15]}}, cal_i.p7, 4'd0};

  always_comb begin
    if ($signed(pr) > ptc_pkg::PRESS_HI) begin
      pq = 25'(ptc_pkg::PRESS_HI);
    end else if ($signed(pr) < ptc_pkg::PRESS_LO) begin
      pq = 25'(ptc_pkg::PRESS_LO);
    end else begin
      pq = pr[24:0];
    end
  end

  // Stage B6: estimate of pascals over 1000, fraction in thousandths.
  logic [29:0]    kp;
  logic [17:0]    fr;
  logic [16:0]    b6_pa_q;
  logic [6:0]     b6_k0_q;
  logic [9:0]     b6_fr_q;
  logic [24:0]    b6_pq_q;
  logic           b6_zero_q;
  ptc_pkg::temp_t b6_temp_q;

  assign kp = 30'(b5_pq_q[24:8]) * 30'(ptc_pkg::RECIP_1000);
  assign fr = 18'(b5_pq_q[7:0]) * 18'd1000;

  // Stage B7: correct the estimate by at most one.
  logic [16:0]    kk;
  logic [16:0]    r0;
  logic           bump;
  logic [6:0]     b7_k_q;
  logic [9:0]     b7_r_q;
  logic [9:0]     b7_fr_q;
  logic [24:0]    b7_pq_q;
  logic           b7_zero_q;
  ptc_pkg::temp_t b7_temp_q;

  assign kk   = 17'(b6_k0_q) * 17'd1000;
  assign r0   = b6_pa_q - kk;
  assign bump = r0 >= 17'd1000;

  // Output register.
  logic [19:0] micro;

  assign micro = 20'(b7_r_q) * 20'd1000 + 20'(b7_fr_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_q_q    <= qneg_q[DivSteps] ? (64'd0 - dq_q[DivSteps]) : dq_q[DivSteps];
      b1_zero_q <= zero_q[DivSteps];
      b1_temp_q <= temp_q[DivSteps];

      b2_q_q    <= b1_q_q;
      b2_s_q    <= sq13;
      b2_c9s_q  <= c9_full[63:0];
      b2_m8_q   <= m8_full[63:0];
      b2_zero_q <= b1_zero_q;
      b2_temp_q <= b1_temp_q;

      b3_pp0_q  <= pp0;
      b3_pp1_q  <= pp1;
      b3_pp2_q  <= pp2;
      b3_x2_q   <= {{19{b2_m8_q[63]}}, b2_m8_q[63:19]};
      b3_q_q    <= b2_q_q;
      b3_zero_q <= b2_zero_q;
      b3_temp_q <= b2_temp_q;

      b4_sum_q  <= b3_q_q + x1v + b3_x2_q;
      b4_zero_q <= b3_zero_q;
      b4_temp_q <= b3_temp_q;

      b5_pq_q   <= pq;
      b5_zero_q <= b4_zero_q;
      b5_temp_q <= b4_temp_q;

      b6_pa_q   <= b5_pq_q[24:8];
      b6_k0_q   <= kp[28:22];
      b6_fr_q   <= fr[17:8];
      b6_pq_q   <= b5_pq_q;
      b6_zero_q <= b5_zero_q;
      b6_temp_q <= b5_temp_q;

      b7_k_q    <= bump ? b6_k0_q + 7'd1 : b6_k0_q;
      b7_r_q    <= bump ? 10'(r0 - 17'd1000) : r0[9:0];
      b7_fr_q   <= b6_fr_q;
      b7_pq_q   <= b6_pq_q;
      b7_zero_q <= b6_zero_q;
      b7_temp_q <= b6_temp_q;

      res_o.temp_centi      <= b7_temp_q.centi;
      res_o.temp_whole      <= b7_temp_q.whole;
      res_o.temp_micro      <= b7_temp_q.micro;
      res_o.fine_temp       <= b7_temp_q.fine;
      res_o.press_q24_8     <= b7_zero_q ? '0 : b7_pq_q;
      res_o.press_kpa_whole <= b7_zero_q ? '0 : b7_k_q;
      res_o.press_micro     <= b7_zero_q ? '0 : micro;
      res_o.press_valid     <= ~b7_zero_q;
    end
  end

  assign res_o.valid = ov_q;

endmodule

### hw/rtl/pressure_temp_compensation.sv
// Throughput: one raw pair per cycle while results are taken; the 64-step pipelined
// divider sets the depth. A four-entry queue parts the front and back pipelines so
// each can stall alone. Reset clears all valid bits, queue pointers and the
// calibration registers to zero. Calibration is written through the plain write port;
// the user must write it only while the block is idle, as the block does not enforce this.
module pressure_temp_compensation #(
  parameter int unsigned QueueDepth = ptc_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ptc_raw_if.sink                       raw_i,
  ptc_res_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptc_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [47:0] temp_cal_q;
  logic [47:0] press_a_q;
  logic [47:0] press_b_q;
  logic [47:0] press_c_q;

  // Calibration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      press_a_q  <= '0;
      press_b_q  <= '0;
      press_c_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptc_pkg::REG_TEMP_CAL:    temp_cal_q <= cfg_data_i;
        ptc_pkg::REG_PRESS_CAL_A: press_a_q  <= cfg_data_i;
        ptc_pkg::REG_PRESS_CAL_B: press_b_q  <= cfg_data_i;
        ptc_pkg::REG_PRESS_CAL_C: press_c_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the twelve calibration words.
  ptc_pkg::cal_t cal;

  assign cal.t1 = temp_cal_q[15:0];
  assign cal.t2 = temp_cal_q[31:16];
  assign cal.t3 = temp_cal_q[47:32];
  assign cal.p1 = press_a_q[15:0];
  assign cal.p2 = press_a_q[31:16];
  assign cal.p3 = press_a_q[47:32];
  assign cal.p4 = press_b_q[15:0];
  assign cal.p5 = press_b_q[31:16];
  assign cal.p6 = press_b_q[47:32];
  assign cal.p7 = press_c_q[15:0];
  assign cal.p8 = press_c_q[31:16];
  assign cal.p9 = press_c_q[47:32];

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  ptc_pkg::qentry_t q_in;
  ptc_pkg::qentry_t q_out;

  ptc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal),
    .raw_i   (raw_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (q_in)
  );

  ptc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_out)
  );

  ptc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal),
    .empty_i (empty),
    .entry_i (q_out),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
